[hw/rtl/dscs_pkg.sv]
package dscs_pkg;

    localparam int NUM_LANES      = 2;
    localparam int NUM_STAGES     = 5;
    localparam int STRIDE_STAGES  = 4;
    localparam int DIV_BITS       = 4;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] GEN_HALF = 8'd128;

    localparam logic BYTE_ORDER_LOW_FIRST  = 1'b0;
    localparam logic BYTE_ORDER_HIGH_FIRST = 1'b1;

    localparam logic STATUS_CHOSEN   = 1'b0;
    localparam logic STATUS_RECOVERY = 1'b1;

    // one slot as it moves down the pipeline
    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] ptr;
        logic        in_range;
        logic [15:0] offset;
        logic [7:0]  crc;
        logic        crc_ok;
        logic [7:0]  rem;
        logic        aligned;
    } lane_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // four restoring remainder steps, dividend bits msb first
    function automatic logic [7:0] div_step(input logic [7:0] rem_in,
                                            input logic [DIV_BITS-1:0] bits,
                                            input logic [7:0] divisor);
        logic [8:0] t;
        logic [7:0] r;
        r = rem_in;
        for (int k = DIV_BITS - 1; k >= 0; k--)
        begin
            t = {r, bits[k]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[7:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/dual_slot_checkpoint_select_unit.sv]
// Picks the live checkpoint out of two redundant 4-byte slots (pointer, generation,
// crc-8 poly 0x07). A new slot pair is taken in every cycle that start is high; busy
// never rises. Each result comes out with done high for one cycle, in start order. The
// pipeline depth is set by the remainder check of the pointer offset against
// record_stride, a 16-bit restoring division cut into four stages of four bits each,
// with the crc bytes folded in alongside it. The receiver cannot stall the block,
// so done must be taken when it appears. The byte order register is written through
// cfg_valid/cfg_ready/cfg_data and must only change while no transaction is in flight.
module dual_slot_checkpoint_select_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  slot_a_byte0,
    input  logic [7:0]  slot_a_byte1,
    input  logic [7:0]  slot_a_byte2,
    input  logic [7:0]  slot_a_byte3,
    input  logic [7:0]  slot_b_byte0,
    input  logic [7:0]  slot_b_byte1,
    input  logic [7:0]  slot_b_byte2,
    input  logic [7:0]  slot_b_byte3,
    input  logic [15:0] region_start,
    input  logic [15:0] region_end,
    input  logic [7:0]  record_stride,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        done,
    output logic        status,
    output logic        chosen_slot,
    output logic [15:0] pointer,
    output logic [7:0]  generation
);
    import dscs_pkg::*;

    logic [7:0] in_bytes [NUM_LANES][4];

    logic                  byte_order_reg;
    logic [NUM_STAGES-1:0] vld_reg;
    lane_t                 lane_reg  [NUM_STAGES][NUM_LANES];
    lane_t                 lane_next [NUM_STAGES][NUM_LANES];
    logic [7:0]            stride_reg [STRIDE_STAGES];

    logic        done_reg;
    logic        status_reg;
    logic        status_next;
    logic        chosen_slot_reg;
    logic        chosen_slot_next;
    logic [15:0] pointer_reg;
    logic [15:0] pointer_next;
    logic [7:0]  generation_reg;
    logic [7:0]  generation_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign in_bytes[0][0] = slot_a_byte0;
    assign in_bytes[0][1] = slot_a_byte1;
    assign in_bytes[0][2] = slot_a_byte2;
    assign in_bytes[0][3] = slot_a_byte3;
    assign in_bytes[1][0] = slot_b_byte0;
    assign in_bytes[1][1] = slot_b_byte1;
    assign in_bytes[1][2] = slot_b_byte2;
    assign in_bytes[1][3] = slot_b_byte3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg <= BYTE_ORDER_LOW_FIRST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            byte_order_reg <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            // stage 0: pointer assembly, range check, offset, first crc byte
            lane_next[0][i].b0 = in_bytes[i][0];
            lane_next[0][i].b1 = in_bytes[i][1];
            lane_next[0][i].b2 = in_bytes[i][2];
            lane_next[0][i].b3 = in_bytes[i][3];
            lane_next[0][i].ptr = (byte_order_reg == BYTE_ORDER_HIGH_FIRST)
                                  ? {in_bytes[i][0], in_bytes[i][1]}
                                  : {in_bytes[i][1], in_bytes[i][0]};
            lane_next[0][i].in_range = (lane_next[0][i].ptr >= region_start)
                                       && (lane_next[0][i].ptr <= region_end);
            lane_next[0][i].offset   = lane_next[0][i].ptr - region_start;
            lane_next[0][i].crc      = crc_byte(CRC_INIT, in_bytes[i][0]);
            lane_next[0][i].crc_ok   = 1'b0;
            lane_next[0][i].rem      = '0;
            lane_next[0][i].aligned  = 1'b0;

            lane_next[1][i]     = lane_reg[0][i];
            lane_next[1][i].crc = crc_byte(lane_reg[0][i].crc, lane_reg[0][i].b1);
            lane_next[1][i].rem = div_step(lane_reg[0][i].rem, lane_reg[0][i].offset[15:12],
                                           stride_reg[0]);

            lane_next[2][i]     = lane_reg[1][i];
            lane_next[2][i].crc = crc_byte(lane_reg[1][i].crc, lane_reg[1][i].b2);
            lane_next[2][i].rem = div_step(lane_reg[1][i].rem, lane_reg[1][i].offset[11:8],
                                           stride_reg[1]);

            lane_next[3][i]        = lane_reg[2][i];
            lane_next[3][i].crc_ok = (lane_reg[2][i].crc == lane_reg[2][i].b3);
            lane_next[3][i].rem    = div_step(lane_reg[2][i].rem, lane_reg[2][i].offset[7:4],
                                              stride_reg[2]);

            lane_next[4][i]         = lane_reg[3][i];
            lane_next[4][i].rem     = div_step(lane_reg[3][i].rem, lane_reg[3][i].offset[3:0],
                                               stride_reg[3]);
            // zero stride never lines up
            lane_next[4][i].aligned = (lane_next[4][i].rem == 8'd0)
                                      && (stride_reg[3] != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], start && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg      <= lane_next;
        stride_reg[0] <= record_stride;
        for (int s = 1; s < STRIDE_STAGES; s++)
        begin
            stride_reg[s] <= stride_reg[s-1];
        end
    end

    // final stage: pick a slot
    always_comb
    begin
        lane_t      l0;
        lane_t      l1;
        logic [7:0] gen_diff;
        logic       bad;
        logic       same;
        logic       recover;
        logic       pick;

        l0       = lane_reg[NUM_STAGES-1][0];
        l1       = lane_reg[NUM_STAGES-1][1];
        gen_diff = l1.b2 - l0.b2;
        same     = (l0.b0 == l1.b0) && (l0.b1 == l1.b1) && (l0.b2 == l1.b2)
                   && (l0.b3 == l1.b3);
        // a slot with a good crc but a bad pointer forces recovery
        bad      = (l0.crc_ok && !(l0.in_range && l0.aligned))
                   || (l1.crc_ok && !(l1.in_range && l1.aligned));
        recover  = 1'b0;
        pick     = 1'b0;

        priority if (bad || (!l0.crc_ok && !l1.crc_ok))
        begin
            recover = 1'b1;
        end
        else if (l0.crc_ok && l1.crc_ok)
        begin
            priority if (gen_diff == 8'd0)
            begin
                recover = !same;
            end
            else if (gen_diff == GEN_HALF)
            begin
                recover = 1'b1;
            end
            else
            begin
                pick = (gen_diff < GEN_HALF);
            end
        end
        else
        begin
            pick = l1.crc_ok;
        end

        if (recover)
        begin
            status_next      = STATUS_RECOVERY;
            chosen_slot_next = 1'b0;
            pointer_next     = '0;
            generation_next  = '0;
        end
        else
        begin
            status_next      = STATUS_CHOSEN;
            chosen_slot_next = pick;
            pointer_next     = pick ? l1.ptr : l0.ptr;
            generation_next  = pick ? l1.b2 : l0.b2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        chosen_slot_reg <= chosen_slot_next;
        pointer_reg     <= pointer_next;
        generation_reg  <= generation_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign chosen_slot = chosen_slot_reg;
    assign pointer     = pointer_reg;
    assign generation  = generation_reg;

`ifndef SYNTH
    // every accepted transaction comes out with done high
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted transaction produced no result");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a matching transaction");

    a_recovery_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_RECOVERY) |->
            (chosen_slot == 1'b0 && pointer == 16'd0 && generation == 8'd0))
        else $error("recovery result carries nonzero fields");

    a_pipe_tail: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NUM_STAGES-1] |=> done)
        else $error("last stage valid lost before output");
`endif

endmodule
